/* rtl/dshot_pkg.sv */
// Shared constants and types for the multi-lane DSHOT frame encoder.
package dshot_pkg;

    localparam int NUM_LANES   = 18;
    localparam int LANE_W      = 5;
    localparam int PIN_MASK_W  = 18;
    localparam int THR_W       = 16;
    localparam int CMD_W       = 11;
    localparam int FRAME_W     = 16;
    localparam int BIT_IDX_W   = 4;
    localparam int VAL_W       = CMD_W + 1;
    localparam int MULT_W      = 11;
    localparam int PROD_W      = THR_W + MULT_W;
    localparam int Q_SHIFT     = 15;
    localparam int MUL_STEPS   = MULT_W;
    localparam int STEP_W      = 4;

    localparam logic [MULT_W-1:0]    K_NORM    = MULT_W'(1999);
    localparam logic [MULT_W-1:0]    K_3D      = MULT_W'(999);
    localparam logic [VAL_W-1:0]     BASE_LOW  = VAL_W'(48);
    localparam logic [VAL_W-1:0]     BASE_3D   = VAL_W'(1048);
    localparam logic [BIT_IDX_W-1:0] BIT_LAST  = BIT_IDX_W'(FRAME_W - 1);

    localparam logic ACT_THROTTLE = 1'b0;
    localparam logic ACT_COMMAND  = 1'b1;

    // Mapper result handed back to the sequencer
    typedef struct packed {
        logic             done;
        logic [CMD_W-1:0] value;
    } map_rsp_t;

endpackage

/* rtl/dshot_thr_map.sv */
// Throttle to DSHOT value mapper built on a shift-add multiplier.
module dshot_thr_map
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic                               mode_3d,
    input  logic signed [dshot_pkg::THR_W-1:0] throttle,
    output dshot_pkg::map_rsp_t                rsp
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } map_state_t;

    map_state_t                        state_reg, state_next;
    logic [dshot_pkg::PROD_W-1:0]      mcand_reg, mcand_next;
    logic [dshot_pkg::PROD_W-1:0]      acc_reg, acc_next;
    logic [dshot_pkg::MULT_W-1:0]      mplier_reg, mplier_next;
    logic [dshot_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                              neg_reg, neg_next;
    logic                              mode_reg, mode_next;
    logic                              done_reg, done_next;
    logic [dshot_pkg::CMD_W-1:0]       value_reg, value_next;

    logic [dshot_pkg::THR_W-1:0]       mag;
    logic [dshot_pkg::CMD_W-1:0]       quot;
    logic [dshot_pkg::VAL_W-1:0]       base;
    logic [dshot_pkg::VAL_W-1:0]       val_sum;

    // |t| fits 16 bits unsigned, including 0x8000
    assign mag  = throttle[dshot_pkg::THR_W-1] ? (~throttle + 1'b1) : throttle;
    assign quot = acc_reg[dshot_pkg::Q_SHIFT +: dshot_pkg::CMD_W];
    assign base = (mode_reg && !neg_reg) ? dshot_pkg::BASE_3D : dshot_pkg::BASE_LOW;
    assign val_sum = base + {1'b0, quot};

    always_comb
    begin
        state_next  = state_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        mode_next   = mode_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (go)
                begin
                    mcand_next  = dshot_pkg::PROD_W'(mag);
                    acc_next    = '0;
                    mplier_next = mode_3d ? dshot_pkg::K_3D : dshot_pkg::K_NORM;
                    step_next   = '0;
                    neg_next    = throttle[dshot_pkg::THR_W-1];
                    mode_next   = mode_3d;
                    state_next  = M_RUN;
                end
            end
            M_RUN:
            begin
                // one multiplier bit per cycle through the accumulator adder
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + 1'b1;
                if (step_reg == dshot_pkg::STEP_W'(dshot_pkg::MUL_STEPS - 1))
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                done_next = 1'b1;
                if ((!mode_reg && neg_reg) || val_sum[dshot_pkg::VAL_W-1]
                    || (val_sum < dshot_pkg::BASE_LOW))
                begin
                    value_next = '0;
                end
                else
                begin
                    value_next = val_sum[dshot_pkg::CMD_W-1:0];
                end
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        step_reg   <= step_next;
        neg_reg    <= neg_next;
        mode_reg   <= mode_next;
        value_reg  <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

    a_go_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != M_IDLE) |-> !go)
        else $error("mapper started while busy");

    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == M_FIN))
        else $error("mapper done without finish step");

    a_stop_neg_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !mode_reg && neg_reg) |-> (value_reg == '0))
        else $error("negative throttle in normal mode not mapped to stop");

endmodule

/* rtl/dshot_multi_lane_frame_encoder.sv */
// Top level of the multi-lane DSHOT frame encoder: lane store, sequencer, emission.
//
// Usage: pulse start with an item while busy is low; the item is taken at that edge.
// action selects a throttle item (mapped to an 11-bit value) or a raw command item.
// Each item writes the 16-bit frame (value, telemetry bit, XOR nibble checksum) of
// one lane; lanes at or above 18 are not stored. An item with last set then sends
// the frame set: 16 beats on pin_mask/bit_index/last_bit, frame MSB first, each
// marked by out_valid for one cycle, back to back. The receiver cannot stall.
// A command item is stored at the edge that takes it; a throttle item runs through
// a shift-add multiplier one coefficient bit per cycle. Emission sends one frame bit
// per beat, shifting every lane register left so the store is empty after the
// sixteenth beat. busy is high while mapping and emitting, not on the last beat. The
// user writes mode_3d via cfg_valid/cfg_data (cfg_ready always high) only while the
// block is idle (not enforced). Reset clears the store, mode_3d and the sequencer.
module dshot_multi_lane_frame_encoder
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   action,
    input  logic [dshot_pkg::LANE_W-1:0]           lane,
    input  logic signed [dshot_pkg::THR_W-1:0]     throttle,
    input  logic [dshot_pkg::CMD_W-1:0]            command,
    input  logic                                   telemetry,
    input  logic                                   last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_data,
    output logic                                   out_valid,
    output logic [dshot_pkg::PIN_MASK_W-1:0]       pin_mask,
    output logic [dshot_pkg::BIT_IDX_W-1:0]        bit_index,
    output logic                                   last_bit
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAP  = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t                          state_reg, state_next;
    logic                                mode_3d_reg;
    logic [dshot_pkg::LANE_W-1:0]        lane_reg;
    logic                                last_reg;
    logic [dshot_pkg::BIT_IDX_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [dshot_pkg::FRAME_W-1:0]       store_reg [dshot_pkg::NUM_LANES];
    logic                                out_valid_reg;
    logic [dshot_pkg::PIN_MASK_W-1:0]    pin_mask_reg, pin_mask_next;
    logic [dshot_pkg::BIT_IDX_W-1:0]     bit_index_reg;
    logic                                last_bit_reg;

    logic                                accept;
    logic                                map_go;
    dshot_pkg::map_rsp_t                 map_rsp;
    logic                                wr_en;
    logic [dshot_pkg::LANE_W-1:0]        wr_lane;
    logic [dshot_pkg::FRAME_W-1:0]       wr_frame;
    logic                                emit;
    logic                                store_any;

    function automatic logic [dshot_pkg::FRAME_W-1:0] make_frame(
        input logic [dshot_pkg::CMD_W-1:0] value,
        input logic                        telem
    );
        logic [dshot_pkg::VAL_W-1:0] word;
        logic [3:0]                  csum;
        word = {value, telem};
        csum = word[11:8] ^ word[7:4] ^ word[3:0];
        return {word, csum};
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign map_go    = accept && (action == dshot_pkg::ACT_THROTTLE);
    assign emit      = (state_reg == ST_EMIT);

    dshot_thr_map u_map
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (map_go),
        .mode_3d  (mode_3d_reg),
        .throttle (throttle),
        .rsp      (map_rsp)
    );

    always_comb
    begin
        wr_en    = 1'b0;
        wr_lane  = lane;
        wr_frame = make_frame(command, telemetry);
        if (map_rsp.done)
        begin
            wr_en    = 1'b1;
            wr_lane  = lane_reg;
            wr_frame = make_frame(map_rsp.value, 1'b0);
        end
        else if (accept && (action == dshot_pkg::ACT_COMMAND))
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                bit_cnt_next = '0;
                if (accept)
                begin
                    if (action == dshot_pkg::ACT_THROTTLE)
                    begin
                        state_next = ST_MAP;
                    end
                    else if (last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MAP:
            begin
                if (map_rsp.done)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == dshot_pkg::BIT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Current frame MSB of every lane forms the beat
    always_comb
    begin
        pin_mask_next = '0;
        store_any     = 1'b0;
        for (int l = 0; l < dshot_pkg::NUM_LANES; l++)
        begin
            store_any = store_any | (|store_reg[l]);
            if (l < dshot_pkg::PIN_MASK_W)
            begin
                pin_mask_next[l] = store_reg[l][dshot_pkg::FRAME_W-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_3d_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < dshot_pkg::NUM_LANES; l++)
            begin
                store_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= emit;
            if (cfg_valid && cfg_ready)
            begin
                mode_3d_reg <= cfg_data;
            end
            for (int l = 0; l < dshot_pkg::NUM_LANES; l++)
            begin
                if (emit)
                begin
                    // shift in zeros: store is clear after the last beat
                    store_reg[l] <= store_reg[l] << 1;
                end
                else if (wr_en && (wr_lane == dshot_pkg::LANE_W'(l)))
                begin
                    store_reg[l] <= wr_frame;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lane_reg <= lane;
            last_reg <= last;
        end
        pin_mask_reg  <= pin_mask_next;
        bit_index_reg <= bit_cnt_reg;
        last_bit_reg  <= (bit_cnt_reg == dshot_pkg::BIT_LAST);
    end

    assign out_valid = out_valid_reg;
    assign pin_mask  = pin_mask_reg;
    assign bit_index = bit_index_reg;
    assign last_bit  = last_bit_reg && out_valid_reg;

    a_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_bit) |=> out_valid)
        else $error("emission beats not contiguous");

    a_last_beat_index: assert property (@(posedge clk) disable iff (!rst_n)
        last_bit |-> (out_valid && (bit_index == dshot_pkg::BIT_LAST)))
        else $error("last beat flagged at wrong bit");

    a_idle_after_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_bit) |-> (!busy && !store_any))
        else $error("store not cleared or block busy after last beat");

    a_map_done_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        map_rsp.done |-> (state_reg == ST_MAP))
        else $error("mapper result outside map state");

endmodule
